[rtl/pem_pkg.sv]
// Shared types and constants for the pulse energy meter.
// No dependencies; every other file but pem_bit_div refers to it by scoped names.
package pem_pkg;

    // Fixed field widths
    localparam int PPK_W    = 16;
    localparam int VOLT_W   = 14;
    localparam int MS_W     = 32;
    localparam int ENERGY_W = 64;
    localparam int PROD1_W  = PPK_W + VOLT_W;
    localparam int PROD_W   = PROD1_W + MS_W;
    localparam int CFG_IDX_W = 3;

    // Default module parameters
    localparam int FRAC_BITS_DEF    = 32;
    localparam int CURRENT_BITS_DEF = 20;

    // Energy adder digit size
    localparam int DIGIT_W        = 4;
    localparam int ENERGY_DIGITS  = ENERGY_W / DIGIT_W;

    // mA numerator: 3600000 s*mA/kWh scale times 1000 ms times 1e4 (dV)
    localparam int CUR_NUM_W = 46;
    localparam logic [CUR_NUM_W-1:0] CUR_NUM = 46'd36000000000000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PPK          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ENERGY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_EN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_EN    = 3'd6;

    // Register reset values
    localparam logic [PPK_W-1:0]    PPK_RST    = 16'd1000;
    localparam logic [ENERGY_W-1:0] STEP_RST   = 64'h0000_0001_0000_0000;
    localparam logic [VOLT_W-1:0]   VOLT_RST   = 14'd2300;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CUR,
        ST_WAIT,
        ST_ENERGY,
        ST_DONE
    } pem_state_t;

    // Status of the serial energy unit
    typedef struct packed {
        logic done;
        logic crossed;
    } pem_energy_stat_t;

endpackage

[rtl/pem_bit_div.sv]
// Restoring divider producing one quotient bit per cycle.
// Uses no package items; instantiated twice by the top level.
module pem_bit_div #(
    parameter int DW = 16,
    parameter int QW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] num_lo,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quotient
);

    localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

    logic          busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic [QW-1:0] num_reg, num_next;
    logic [QW-1:0] q_reg, q_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    assign shifted = {rem_reg, num_reg[QW-1]};
    assign fits    = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW - 1);
            rem_next  = rem_init;
            div_next  = divisor;
            num_next  = num_lo;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
            num_next = {num_reg[QW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

[rtl/pem_energy_acc.sv]
// Digit-serial energy accumulator: saturating add and report-step compare.
// Depends on pem_pkg for widths and the status struct.
module pem_energy_acc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [pem_pkg::ENERGY_W-1:0]  load_value,
    input  logic                          start,
    input  logic [pem_pkg::ENERGY_W-1:0]  inc,
    input  logic [pem_pkg::ENERGY_W-1:0]  step,
    output logic [pem_pkg::ENERGY_W-1:0]  acc,
    output pem_pkg::pem_energy_stat_t     stat
);

    localparam int EW    = pem_pkg::ENERGY_W;
    localparam int DW    = pem_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(pem_pkg::ENERGY_DIGITS);

    logic [EW-1:0]    acc_reg, acc_next;
    logic [EW-1:0]    lr_reg, lr_next;
    logic [EW-1:0]    inc_reg, inc_next;
    logic [EW-1:0]    step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             c_acc_reg, c_acc_next;
    logic             c_thr_reg, c_thr_next;
    logic             le_reg, le_next;
    logic             done_reg, done_next;
    logic             crossed_reg, crossed_next;
    logic [DW:0]      sum_d;
    logic [DW:0]      thr_d;
    logic [EW-1:0]    acc_rot;
    logic [EW-1:0]    lr_rot;

    assign sum_d = {1'b0, acc_reg[DW-1:0]} + {1'b0, inc_reg[DW-1:0]} + {{DW{1'b0}}, c_acc_reg};
    assign thr_d = {1'b0, lr_reg[DW-1:0]} + {1'b0, step_reg[DW-1:0]} + {{DW{1'b0}}, c_thr_reg};
    assign acc_rot = {sum_d[DW-1:0], acc_reg[EW-1:DW]};
    assign lr_rot  = {lr_reg[DW-1:0], lr_reg[EW-1:DW]};

    always_comb
    begin
        acc_next     = acc_reg;
        lr_next      = lr_reg;
        inc_next     = inc_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        c_acc_next   = c_acc_reg;
        c_thr_next   = c_thr_reg;
        le_next      = le_reg;
        done_next    = 1'b0;
        crossed_next = crossed_reg;
        // digit compare, least significant first: later digits override
        if (thr_d[DW-1:0] < sum_d[DW-1:0])
        begin
            le_next = 1'b1;
        end
        else if (thr_d[DW-1:0] > sum_d[DW-1:0])
        begin
            le_next = 1'b0;
        end
        if (load)
        begin
            acc_next = load_value;
            lr_next  = load_value;
        end
        else if (start)
        begin
            inc_next   = inc;
            step_next  = step;
            cnt_next   = '0;
            busy_next  = 1'b1;
            c_acc_next = 1'b0;
            c_thr_next = 1'b0;
            le_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            inc_next   = {{DW{1'b0}}, inc_reg[EW-1:DW]};
            step_next  = {{DW{1'b0}}, step_reg[EW-1:DW]};
            c_acc_next = sum_d[DW];
            c_thr_next = thr_d[DW];
            cnt_next   = cnt_reg + 1'b1;
            acc_next   = acc_rot;
            lr_next    = lr_rot;
            if (cnt_reg == CNT_W'(pem_pkg::ENERGY_DIGITS - 1))
            begin
                // last digit: saturate, then decide on the report step
                busy_next    = 1'b0;
                done_next    = 1'b1;
                acc_next     = sum_d[DW] ? '1 : acc_rot;
                crossed_next = !thr_d[DW] && (sum_d[DW] || le_next);
                if (crossed_next)
                begin
                    lr_next = acc_next;
                end
            end
        end
        else
        begin
            le_next = le_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            lr_reg      <= '0;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            crossed_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            lr_reg      <= lr_next;
            cnt_reg     <= cnt_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            crossed_reg <= crossed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_reg   <= inc_next;
        step_reg  <= step_next;
        c_acc_reg <= c_acc_next;
        c_thr_reg <= c_thr_next;
        le_reg    <= le_next;
    end

    assign acc          = acc_reg;
    assign stat.done    = done_reg;
    assign stat.crossed = crossed_reg;

endmodule

[rtl/pulse_energy_meter_unit.sv]
// Top level of the pulse energy meter: configuration, edge detection, control.
// Depends on pem_pkg, pem_bit_div and pem_energy_acc.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | pulse_level
//  output   | out_valid / out_stall | line_level pulse_seen energy_total
//           |                       | energy_report current_ma current_valid
//  config   | cfg_we                | cfg_index cfg_data
//
// A tick without a pulse goes from IDLE straight to DONE. A pulse tick steps through
// MUL, CUR, WAIT, ENERGY and DONE: the bit-serial increment divider (FRAC_BITS + 1
// steps) runs alongside the current multiply and divider (CURRENT_BITS steps), then
// the energy adder walks 64 bits in 4-bit digits.
// One request is worked on at a time; a new request is taken while the previous
// result still sits in the output register, and the result waits there until out_stall
// drops. Reset loads the register defaults and clears the energy to zero; no sweep.
module pulse_energy_meter_unit #(
    parameter int FRAC_BITS    = pem_pkg::FRAC_BITS_DEF,
    parameter int CURRENT_BITS = pem_pkg::CURRENT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [pem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pem_pkg::ENERGY_W-1:0]      cfg_data,
    // tick requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              pulse_level,
    // results
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              line_level,
    output logic                              pulse_seen,
    output logic [pem_pkg::ENERGY_W-1:0]      energy_total,
    output logic                              energy_report,
    output logic [CURRENT_BITS-1:0]           current_ma,
    output logic                              current_valid
);

    localparam int EW      = pem_pkg::ENERGY_W;
    localparam int INC_W   = FRAC_BITS + 1;
    localparam int PROD_W  = pem_pkg::PROD_W;
    localparam int PROD1_W = pem_pkg::PROD1_W;
    localparam logic [CURRENT_BITS-1:0] CUR_MAX = '1;
    // any divisor at or below this limit gives a quotient that saturates
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(pem_pkg::CUR_NUM >> CURRENT_BITS);

    // configuration registers
    logic [pem_pkg::PPK_W-1:0]  ppk_reg;
    logic [EW-1:0]              step_reg;
    logic [pem_pkg::VOLT_W-1:0] volt_reg;
    logic                       edge_mode_reg;
    logic                       cur_en_reg;
    logic                       rep_en_reg;

    // tracking state
    pem_pkg::pem_state_t        state_reg, state_next;
    logic                       prev_level_reg;
    logic [pem_pkg::MS_W-1:0]   ms_reg;
    logic [pem_pkg::MS_W-1:0]   interval_reg;
    logic [CURRENT_BITS-1:0]    last_cur_reg;
    logic [PROD1_W-1:0]         prod1_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       cur_sat_reg;

    // staged result fields
    logic                       res_level_reg;
    logic                       res_pulse_reg;
    logic                       res_report_reg;
    logic                       res_cvalid_reg;

    // output register
    logic                       out_valid_reg;
    logic                       line_level_reg;
    logic                       pulse_seen_reg;
    logic [EW-1:0]              energy_total_reg;
    logic                       energy_report_reg;
    logic [CURRENT_BITS-1:0]    current_ma_reg;
    logic                       current_valid_reg;

    // control
    logic                       accept;
    logic                       pulse_now;
    logic                       busy_c;
    logic                       inc_start;
    logic                       cur_start;
    logic                       e_start;
    logic                       out_load;
    logic                       out_free;
    logic                       divs_idle;
    logic                       cur_sat_now;
    logic [pem_pkg::PPK_W-1:0]  ppk_eff;

    // unit connections
    logic                       inc_busy;
    logic [INC_W-1:0]           inc_q;
    logic                       cur_busy;
    logic [CURRENT_BITS-1:0]    cur_q;
    logic [EW-1:0]              acc;
    pem_pkg::pem_energy_stat_t  e_stat;
    logic                       e_load;

    assign ppk_eff   = (ppk_reg == '0) ? pem_pkg::PPK_W'(1) : ppk_reg;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign divs_idle = !inc_busy && !cur_busy;
    assign e_load    = cfg_we && (cfg_index == pem_pkg::REG_START_ENERGY);

    // polled mode counts a falling edge, interrupt mode a rising edge
    assign pulse_now = edge_mode_reg ? (!prev_level_reg && pulse_level)
                                     : (prev_level_reg && !pulse_level);

    // zero divisor (zero interval or voltage) and oversize quotients saturate
    assign cur_sat_now = (prod_reg == '0) || (prod_reg <= SAT_LIMIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pem_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pulse_now ? pem_pkg::ST_MUL : pem_pkg::ST_DONE;
                end
            end
            pem_pkg::ST_MUL:    state_next = pem_pkg::ST_CUR;
            pem_pkg::ST_CUR:    state_next = pem_pkg::ST_WAIT;
            pem_pkg::ST_WAIT:
            begin
                if (divs_idle)
                begin
                    state_next = pem_pkg::ST_ENERGY;
                end
            end
            pem_pkg::ST_ENERGY:
            begin
                if (e_stat.done)
                begin
                    state_next = pem_pkg::ST_DONE;
                end
            end
            pem_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = pem_pkg::ST_IDLE;
                end
            end
            default:            state_next = pem_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy_c    = 1'b1;
        inc_start = 1'b0;
        cur_start = 1'b0;
        e_start   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            pem_pkg::ST_IDLE:
            begin
                busy_c    = 1'b0;
                inc_start = accept && pulse_now;
            end
            pem_pkg::ST_MUL:    busy_c = 1'b1;
            pem_pkg::ST_CUR:    cur_start = cur_en_reg && !cur_sat_now;
            pem_pkg::ST_WAIT:   e_start = divs_idle;
            pem_pkg::ST_ENERGY: busy_c = 1'b1;
            pem_pkg::ST_DONE:   out_load = out_free;
            default:            busy_c = 1'b1;
        endcase
    end

    assign in_stall = busy_c;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppk_reg       <= pem_pkg::PPK_RST;
            step_reg      <= pem_pkg::STEP_RST;
            volt_reg      <= pem_pkg::VOLT_RST;
            edge_mode_reg <= 1'b0;
            cur_en_reg    <= 1'b0;
            rep_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pem_pkg::REG_PPK:         ppk_reg       <= cfg_data[pem_pkg::PPK_W-1:0];
                pem_pkg::REG_REPORT_STEP: step_reg      <= cfg_data;
                pem_pkg::REG_VOLTAGE:     volt_reg      <= cfg_data[pem_pkg::VOLT_W-1:0];
                pem_pkg::REG_EDGE_MODE:   edge_mode_reg <= cfg_data[0];
                pem_pkg::REG_CURRENT_EN:  cur_en_reg    <= cfg_data[0];
                pem_pkg::REG_REPORT_EN:   rep_en_reg    <= cfg_data[0];
                default:                  ppk_reg       <= ppk_reg;
            endcase
        end
    end

    // sequencing and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= pem_pkg::ST_IDLE;
            prev_level_reg    <= 1'b1;
            ms_reg            <= '0;
            last_cur_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                prev_level_reg <= pulse_level;
                // restart the interval on a pulse, else count up and hold at the top
                if (pulse_now)
                begin
                    ms_reg <= '0;
                end
                else if (ms_reg != '1)
                begin
                    ms_reg <= ms_reg + 1'b1;
                end
            end
            if (e_start && cur_en_reg)
            begin
                last_cur_reg <= cur_sat_reg ? CUR_MAX : cur_q;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and result staging
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_level_reg  <= pulse_level;
            res_pulse_reg  <= pulse_now;
            res_report_reg <= 1'b0;
            res_cvalid_reg <= 1'b0;
            interval_reg   <= ms_reg;
            prod1_reg      <= PROD1_W'(ppk_eff) * PROD1_W'(volt_reg);
        end
        if (state_reg == pem_pkg::ST_MUL)
        begin
            prod_reg <= PROD_W'(prod1_reg) * PROD_W'(interval_reg);
        end
        if (state_reg == pem_pkg::ST_CUR)
        begin
            cur_sat_reg <= cur_sat_now;
        end
        if (e_start)
        begin
            res_cvalid_reg <= cur_en_reg;
        end
        if ((state_reg == pem_pkg::ST_ENERGY) && e_stat.done)
        begin
            res_report_reg <= e_stat.crossed && rep_en_reg;
        end
        if (out_load)
        begin
            line_level_reg    <= res_level_reg;
            pulse_seen_reg    <= res_pulse_reg;
            energy_total_reg  <= acc;
            energy_report_reg <= res_report_reg;
            current_ma_reg    <= last_cur_reg;
            current_valid_reg <= res_cvalid_reg;
        end
    end

    // increment: floor(2^FRAC_BITS / pulses_per_kwh)
    pem_bit_div #(
        .DW (pem_pkg::PPK_W),
        .QW (INC_W)
    ) u_inc_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (inc_start),
        .rem_init ('0),
        .num_lo   (INC_W'(1) << FRAC_BITS),
        .divisor  (ppk_eff),
        .busy     (inc_busy),
        .quotient (inc_q)
    );

    // current: low CURRENT_BITS quotient bits; the upper part is known to be zero
    pem_bit_div #(
        .DW (PROD_W),
        .QW (CURRENT_BITS)
    ) u_cur_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cur_start),
        .rem_init (SAT_LIMIT),
        .num_lo   (pem_pkg::CUR_NUM[CURRENT_BITS-1:0]),
        .divisor  (prod_reg),
        .busy     (cur_busy),
        .quotient (cur_q)
    );

    pem_energy_acc u_energy (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (e_load),
        .load_value (cfg_data),
        .start      (e_start),
        .inc        (EW'(inc_q)),
        .step       (step_reg),
        .acc        (acc),
        .stat       (e_stat)
    );

    assign out_valid     = out_valid_reg;
    assign line_level    = line_level_reg;
    assign pulse_seen    = pulse_seen_reg;
    assign energy_total  = energy_total_reg;
    assign energy_report = energy_report_reg;
    assign current_ma    = current_ma_reg;
    assign current_valid = current_valid_reg;

endmodule

[dv/pem_checker.sv]
// Checker for the pulse energy meter: watches the config port and both channels,
// predicts each tick's reading and compares it field by field with the block's output.
// Depends on pem_pkg for the register indexes and reset values.
module pem_checker #(
    parameter int FRAC_BITS    = pem_pkg::FRAC_BITS_DEF,
    parameter int CURRENT_BITS = pem_pkg::CURRENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pem_pkg::ENERGY_W-1:0]  cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          pulse_level,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          line_level,
    input  logic                          pulse_seen,
    input  logic [pem_pkg::ENERGY_W-1:0]  energy_total,
    input  logic                          energy_report,
    input  logic [CURRENT_BITS-1:0]       current_ma,
    input  logic                          current_valid,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MA_NUMERATOR = 64'd36000000000000;
    localparam logic [63:0] MA_MAX       = (64'd1 << CURRENT_BITS) - 64'd1;
    localparam logic [63:0] ENERGY_FULL  = '1;

    typedef struct {
        logic                    line;
        logic                    pulse;
        logic [63:0]             energy;
        logic                    report;
        logic [CURRENT_BITS-1:0] ma;
        logic                    ma_vld;
    } reading_t;

    // Register copies
    logic [pem_pkg::PPK_W-1:0]  ppk_reg;
    logic [63:0]                step_reg;
    logic [pem_pkg::VOLT_W-1:0] volt_reg;
    logic                       rising_reg;
    logic                       cur_en_reg;
    logic                       rep_en_reg;

    // Meter state
    logic        prev_level;
    logic [31:0] ms_count;
    logic [63:0] energy;
    logic [63:0] reported;
    logic [63:0] held_ma;

    reading_t due_readings[$];
    int       bad;

    // Advance the meter by one tick and return what the block should show.
    function automatic reading_t meter_tick(logic lvl);
        reading_t    r;
        logic        hit;
        logic [63:0] ppk_eff;
        logic [63:0] inc;
        logic [63:0] divisor;
        logic [63:0] quot;
        logic [64:0] threshold;
        ppk_eff = (ppk_reg == '0) ? 64'd1 : 64'(ppk_reg);
        hit = rising_reg ? (!prev_level && lvl) : (prev_level && !lvl);
        prev_level = lvl;
        r.report = 1'b0;
        r.ma_vld = 1'b0;
        if (hit)
        begin
            inc = (64'd1 << FRAC_BITS) / ppk_eff;
            divisor = ppk_eff * 64'(ms_count) * 64'(volt_reg);
            ms_count = '0;
            energy = (energy > ENERGY_FULL - inc) ? ENERGY_FULL : energy + inc;
            if (cur_en_reg)
            begin
                quot = (divisor == 64'd0) ? MA_MAX : MA_NUMERATOR / divisor;
                held_ma = (quot > MA_MAX) ? MA_MAX : quot;
                r.ma_vld = 1'b1;
            end
            // a threshold past 64 bits is never reached
            threshold = {1'b0, reported} + {1'b0, step_reg};
            if (threshold <= {1'b0, energy})
            begin
                reported = energy;
                r.report = rep_en_reg;
            end
        end
        else if (ms_count != 32'hFFFF_FFFF)
        begin
            ms_count = ms_count + 32'd1;
        end
        r.line   = lvl;
        r.pulse  = hit;
        r.energy = energy;
        r.ma     = held_ma[CURRENT_BITS-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            bad++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t want;
        if (!rst_n)
        begin
            ppk_reg     = pem_pkg::PPK_RST;
            step_reg    = pem_pkg::STEP_RST;
            volt_reg    = pem_pkg::VOLT_RST;
            rising_reg  = 1'b0;
            cur_en_reg  = 1'b0;
            rep_en_reg  = 1'b0;
            prev_level  = 1'b1;
            ms_count    = '0;
            energy      = '0;
            reported    = '0;
            held_ma     = '0;
            bad         = 0;
            due_readings.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_readings.size() == 0)
                begin
                    $error("result with no request pending");
                    bad++;
                end
                else
                begin
                    want = due_readings.pop_front();
                    check_field("line_level", 64'(want.line), 64'(line_level));
                    check_field("pulse_seen", 64'(want.pulse), 64'(pulse_seen));
                    check_field("energy_total", want.energy, energy_total);
                    check_field("energy_report", 64'(want.report), 64'(energy_report));
                    check_field("current_ma", 64'(want.ma), 64'(current_ma));
                    check_field("current_valid", 64'(want.ma_vld), 64'(current_valid));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    pem_pkg::REG_PPK:          ppk_reg = cfg_data[pem_pkg::PPK_W-1:0];
                    pem_pkg::REG_START_ENERGY:
                    begin
                        energy   = cfg_data;
                        reported = cfg_data;
                    end
                    pem_pkg::REG_REPORT_STEP:  step_reg = cfg_data;
                    pem_pkg::REG_VOLTAGE:      volt_reg = cfg_data[pem_pkg::VOLT_W-1:0];
                    pem_pkg::REG_EDGE_MODE:    rising_reg = cfg_data[0];
                    pem_pkg::REG_CURRENT_EN:   cur_en_reg = cfg_data[0];
                    pem_pkg::REG_REPORT_EN:    rep_en_reg = cfg_data[0];
                    default:                   ;
                endcase
            end
            if (in_valid && !in_stall)
                due_readings.push_back(meter_tick(pulse_level));
            mismatches  <= bad;
            outstanding <= due_readings.size();
        end
    end

endmodule

[dv/pulse_energy_meter_unit_tb.sv]
// Testbench top for the pulse energy meter: clock, reset, config writes, tick requests
// and output stalls; the verdict comes from the failure and pending counts of pem_checker.
// Depends on pem_pkg, pem_checker and pulse_energy_meter_unit.
module pulse_energy_meter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CURRENT_BITS = pem_pkg::CURRENT_BITS_DEF;
    localparam int IDX_W        = pem_pkg::CFG_IDX_W;
    localparam int EN_W         = pem_pkg::ENERGY_W;
    // index with no register behind it; a write must change nothing
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    // settle well past the length of a pulse tick before a config write
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 8;
    localparam int PHASE_TICKS   = 75;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [IDX_W-1:0]        cfg_index;
    logic [EN_W-1:0]         cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    pulse_level;
    logic                    out_valid;
    logic                    out_stall;
    logic                    line_level;
    logic                    pulse_seen;
    logic [EN_W-1:0]         energy_total;
    logic                    energy_report;
    logic [CURRENT_BITS-1:0] current_ma;
    logic                    current_valid;
    int                      mismatches;
    int                      outstanding;

    // Idling controls shared by the sender and receiver processes
    bit calm_tx;
    bit calm_rx;
    bit hold_req;

    pulse_energy_meter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pulse_level   (pulse_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_level    (line_level),
        .pulse_seen    (pulse_seen),
        .energy_total  (energy_total),
        .energy_report (energy_report),
        .current_ma    (current_ma),
        .current_valid (current_valid)
    );

    pem_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pulse_level   (pulse_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_level    (line_level),
        .pulse_seen    (pulse_seen),
        .energy_total  (energy_total),
        .energy_report (energy_report),
        .current_ma    (current_ma),
        .current_valid (current_valid),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // 4 ns clock, first rising edge at 2 ns
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Gap before a request: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_tx || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Write one register. Drop the enable on the following edge so that two writes
    // in a row never assign cfg_we twice in one step.
    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [EN_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one tick request and hold it until the block accepts it. Called at a
    // rising edge; returns at the edge of acceptance with in_valid still high.
    task automatic send_tick(input logic lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pulse_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Send ticks spelled out as a string of '0' and '1' line samples.
    task automatic send_pattern(input string levels);
        for (int i = 0; i < levels.len(); i++)
            send_tick(levels[i] == "1");
    endtask

    // Random ticks: mostly square pulse trains with random run lengths (so intervals
    // and edges vary), the rest single random samples as line noise.
    task automatic run_ticks(input int count);
        int   sent;
        int   run;
        logic lvl;
        sent = 0;
        lvl  = 1'($urandom_range(0, 1));
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 5);
                repeat (run)
                begin
                    if (sent < count)
                    begin
                        send_tick(lvl);
                        sent++;
                    end
                end
                lvl = ~lvl;
            end
            else
            begin
                send_tick(1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Stop offering, wait until every reading has come back, then let the block settle.
    // Skip an edge first: the checker's count is registered, so it lags acceptance.
    task automatic drain_readings();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pick a random configuration, biased toward the edges of each range and toward
    // report steps that a phase of ticks can actually cross.
    task automatic random_setup(input bit near_top);
        logic [pem_pkg::PPK_W-1:0]  ppk;
        logic [pem_pkg::VOLT_W-1:0] volt;
        logic [EN_W-1:0]            inc;
        logic [EN_W-1:0]            step;
        logic [EN_W-1:0]            start;
        case ($urandom_range(0, 3))
            0:       ppk = 16'd1;
            1:       ppk = 16'hFFFF;
            2:       ppk = 16'($urandom_range(1, 20));
            default: ppk = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       volt = 14'd1;
            1:       volt = 14'd10000;
            default: volt = 14'($urandom_range(1, 10000));
        endcase
        inc = 64'h1_0000_0000 / ppk;
        case ($urandom_range(0, 7))
            0:       step = '0;
            1:       step = {$urandom, $urandom};
            2:       step = '1;
            default: step = inc * $urandom_range(1, 8);
        endcase
        if (near_top)
            start = 64'hFFFF_FFFF_FFFF_FFFF - inc * $urandom_range(0, 20);
        else if ($urandom_range(0, 1) == 1)
            start = {$urandom, $urandom};
        else
            start = '0;
        set_reg(pem_pkg::REG_PPK, 64'(ppk));
        set_reg(pem_pkg::REG_VOLTAGE, 64'(volt));
        set_reg(pem_pkg::REG_REPORT_STEP, step);
        set_reg(pem_pkg::REG_START_ENERGY, start);
        set_reg(pem_pkg::REG_EDGE_MODE, 64'($urandom_range(0, 1)));
        set_reg(pem_pkg::REG_CURRENT_EN, 64'($urandom_range(0, 3) != 0));
        set_reg(pem_pkg::REG_REPORT_EN, 64'($urandom_range(0, 3) != 0));
    endtask

    // Receiver: random stalls, with one long hold-off on request counted here.
    initial
    begin : receiver
        int hold;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req  <= 1'b0;
            end
            else if (!calm_rx && $urandom_range(0, 3) == 0)
            begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        pulse_level <= 1'b0;
        calm_tx     = 1'b0;
        calm_rx     = 1'b0;
        hold_req    <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults with current and reports on. The first tick is a falling edge
        // right after reset, so its interval is zero and the current saturates.
        set_reg(pem_pkg::REG_CURRENT_EN, 64'd1);
        set_reg(pem_pkg::REG_REPORT_EN, 64'd1);
        send_pattern("0110010");
        drain_readings();

        // One pulse per kWh (every pulse crosses the default step), top voltage,
        // rising edges counted.
        set_reg(pem_pkg::REG_PPK, 64'd1);
        set_reg(pem_pkg::REG_VOLTAGE, 64'd10000);
        set_reg(pem_pkg::REG_EDGE_MODE, 64'd1);
        send_pattern("010110");
        drain_readings();

        // Top pulse rate, lowest voltage, zero step, energy preset just below full:
        // the accumulator saturates and stays there.
        set_reg(pem_pkg::REG_PPK, 64'hFFFF);
        set_reg(pem_pkg::REG_VOLTAGE, 64'd1);
        set_reg(pem_pkg::REG_REPORT_STEP, 64'd0);
        set_reg(pem_pkg::REG_START_ENERGY, 64'hFFFF_FFFF_FFFE_FFFF);
        set_reg(pem_pkg::REG_EDGE_MODE, 64'd0);
        send_pattern("1010");
        drain_readings();

        // Zero pulse rate acts as one, zero voltage saturates the current, and a
        // maximal step pushes the threshold past 64 bits so no report comes.
        set_reg(pem_pkg::REG_PPK, 64'd0);
        set_reg(pem_pkg::REG_VOLTAGE, 64'd0);
        set_reg(pem_pkg::REG_REPORT_STEP, '1);
        set_reg(pem_pkg::REG_START_ENERGY, 64'd5);
        send_pattern("1010");
        drain_readings();

        // Current off (held value shows), reports off while crossings still advance
        // the last reported energy; also hit the index that has no register.
        set_reg(pem_pkg::REG_PPK, 64'd4);
        set_reg(pem_pkg::REG_VOLTAGE, 64'd2300);
        set_reg(pem_pkg::REG_REPORT_STEP, 64'h4000_0000);
        set_reg(pem_pkg::REG_CURRENT_EN, 64'd0);
        set_reg(pem_pkg::REG_REPORT_EN, 64'd0);
        set_reg(REG_UNUSED, {$urandom, $urandom});
        send_pattern("10101");
        drain_readings();

        // Random phases. Phase 2 runs with no idling on either side; phase 4 keeps
        // the sender busy while the receiver holds off, so the block backs up and
        // stalls its input. Phases 3 and 6 start near full energy.
        for (int p = 0; p < PHASES; p++)
        begin
            random_setup(p == 3 || p == 6);
            calm_tx = (p == 2 || p == 4);
            calm_rx = (p == 2);
            if (p == 4)
                hold_req <= 1'b1;
            run_ticks(PHASE_TICKS);
            drain_readings();
        end

        repeat (60) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
